// ===== hw/rtl/btlp_pkg.sv =====
// ----------------------------------------------------------------------------
// btlp_pkg
// Types and constants shared by the BER tag/length header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package btlp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TagW  = 28;
  localparam int unsigned LenW  = 32;
  localparam int unsigned HdrW  = 4;

  localparam logic [4:0] TagEscape = 5'h1F;

  typedef enum logic [1:0] {
    PH_IDENT,
    PH_TAG,
    PH_LEN,
    PH_LENOCT
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_LEN_OCTETS,
    ST_BUF_END,
    ST_TAG_LONG
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      tag_class;
    logic            is_constructed;
    logic [TagW-1:0] tag_number;
    logic [LenW-1:0] content_length;
    logic [HdrW-1:0] header_size;
    status_e         status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ber_tag_length_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ber_tag_length_header_parser_unit
// ASN.1 BER identifier and length header parser, one byte per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one header byte and
// an end-of-buffer flag per transfer. Output channel (out_valid_o/out_ready_i/
// out_data_o) carries one result per finished header: class, constructed
// bit, tag number, content length, header size and status. Bytes that do not
// finish a header produce no output transfer.
// Throughput: one byte per cycle while no result stalls on out_ready_i, set by
// the combinational parse step between the input and result registers.
// Path: the byte that ends the header passes the input register, the parse
// step and the result register before its result is presented.
// Reset: clears both pipeline registers and returns the parser to expecting
// an identifier byte.
// Stall: while a result waits on out_ready_i, at most one more byte is taken
// into the input register; after that in_ready_o drops until the result is
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ber_tag_length_header_parser_unit #(
  parameter int unsigned MAX_LENGTH_OCTETS = 4,
  parameter int unsigned MAX_TAG_OCTETS    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  btlp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output btlp_pkg::out_item_t out_data_o
);

  import btlp_pkg::*;

  logic      s1_valid;
  logic      res_ready;
  in_item_t  s1_item;
  logic      emit;
  out_item_t result;

  btlp_pipe_reg #(
    .T(in_item_t)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .ready_i (res_ready),
    .data_o  (s1_item)
  );

  btlp_core #(
    .MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS),
    .MAX_TAG_OCTETS   (MAX_TAG_OCTETS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_valid && res_ready),
    .item_i   (s1_item),
    .emit_o   (emit),
    .result_o (result)
  );

  btlp_pipe_reg #(
    .T(out_item_t)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid && emit),
    .ready_o (res_ready),
    .data_i  (result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/btlp_pipe_reg.sv =====
// ----------------------------------------------------------------------------
// btlp_pipe_reg
// One valid/ready pipeline register; takes a new transfer while the held one
// leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btlp_pipe_reg #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/btlp_core.sv =====
// ----------------------------------------------------------------------------
// btlp_core
// Header parse state and one-byte step logic; flags a result when the
// identifier and length octets are complete or an error ends the header.
// ----------------------------------------------------------------------------
`default_nettype none

module btlp_core #(
  parameter int unsigned MAX_LENGTH_OCTETS = 4,
  parameter int unsigned MAX_TAG_OCTETS    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  btlp_pkg::in_item_t   item_i,
  output logic                 emit_o,
  output btlp_pkg::out_item_t  result_o
);

  import btlp_pkg::*;

  localparam int unsigned TcW = $clog2(MAX_TAG_OCTETS + 1);
  localparam int unsigned LcW = $clog2(MAX_LENGTH_OCTETS + 1);

  phase_e          phase_q, phase_d;
  logic [1:0]      class_q, class_d;
  logic            cons_q, cons_d;
  logic [TagW-1:0] tag_q, tag_d;
  logic [TcW-1:0]  tag_cnt_q, tag_cnt_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LcW-1:0]  len_left_q, len_left_d;
  logic [HdrW-1:0] bytes_q, bytes_d;

  logic [ByteW-1:0] b;
  logic             emit;
  status_e          status;
  logic [LenW-1:0]  len_out;

  always_comb begin
    b          = item_i.data_byte;
    phase_d    = phase_q;
    class_d    = class_q;
    cons_d     = cons_q;
    tag_d      = tag_q;
    tag_cnt_d  = tag_cnt_q;
    len_d      = len_q;
    len_left_d = len_left_q;
    bytes_d    = bytes_q + HdrW'(1);
    emit       = 1'b0;
    status     = ST_OK;
    len_out    = '0;

    case (phase_q)
      PH_IDENT: begin
        class_d = b[7:6];
        cons_d  = b[5];
        if (b[4:0] != TagEscape) begin
          tag_d   = {{(TagW-5){1'b0}}, b[4:0]};
          phase_d = PH_LEN;
        end else begin
          tag_d     = '0;
          tag_cnt_d = '0;
          phase_d   = PH_TAG;
        end
      end
      PH_TAG: begin
        tag_d     = {tag_q[TagW-8:0], b[6:0]};
        tag_cnt_d = tag_cnt_q + TcW'(1);
        if (b[7]) begin
          if (tag_cnt_d >= TcW'(MAX_TAG_OCTETS)) begin
            emit   = 1'b1;
            status = ST_TAG_LONG;
          end
        end else begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (!b[7]) begin
          emit    = 1'b1;
          len_out = {{(LenW-ByteW){1'b0}}, b};
        end else if (b[6:0] > 7'(MAX_LENGTH_OCTETS)) begin
          emit   = 1'b1;
          status = ST_LEN_OCTETS;
        end else if (b[6:0] == 7'd0) begin
          emit = 1'b1;
        end else begin
          len_d      = '0;
          len_left_d = LcW'(b[6:0]);
          phase_d    = PH_LENOCT;
        end
      end
      PH_LENOCT: begin
        len_d = {len_q[LenW-ByteW-1:0], b};
        if (len_left_q != '0) begin
          len_left_d = len_left_q - LcW'(1);
        end
        if (len_left_d == '0) begin
          emit    = 1'b1;
          len_out = len_d;
        end
      end
      default: begin
        phase_d = PH_IDENT;
      end
    endcase

    if (!emit && item_i.end_of_buffer) begin
      emit   = 1'b1;
      status = ST_BUF_END;
    end

    result_o.tag_class      = class_d;
    result_o.is_constructed = cons_d;
    result_o.tag_number     = tag_d;
    result_o.content_length = (status == ST_OK) ? len_out : '0;
    result_o.header_size    = bytes_d;
    result_o.status         = status;
  end

  assign emit_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDENT;
      class_q    <= '0;
      cons_q     <= 1'b0;
      tag_q      <= '0;
      tag_cnt_q  <= '0;
      len_q      <= '0;
      len_left_q <= '0;
      bytes_q    <= '0;
    end else if (step_i) begin
      if (emit) begin
        phase_q    <= PH_IDENT;
        class_q    <= '0;
        cons_q     <= 1'b0;
        tag_q      <= '0;
        tag_cnt_q  <= '0;
        len_q      <= '0;
        len_left_q <= '0;
        bytes_q    <= '0;
      end else begin
        phase_q    <= phase_d;
        class_q    <= class_d;
        cons_q     <= cons_d;
        tag_q      <= tag_d;
        tag_cnt_q  <= tag_cnt_d;
        len_q      <= len_d;
        len_left_q <= len_left_d;
        bytes_q    <= bytes_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/btlp_checker.sv =====
// ----------------------------------------------------------------------------
// btlp_checker
// Port-level checks for the header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module btlp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input btlp_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input btlp_pkg::out_item_t out_data_o
);

  import btlp_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transfer withdrawn or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  a_err_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.content_length == '0)
    else $error("error result carries a nonzero length");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

endmodule

bind ber_tag_length_header_parser_unit btlp_checker u_btlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
